// ===== sv/interval_scheduling_count_macros.svh =====
// Assertion macros shared by the interval scheduling counter modules.
`ifndef INTERVAL_SCHEDULING_COUNT_MACROS_SVH
`define INTERVAL_SCHEDULING_COUNT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ISC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ISC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/isc_pkg.sv =====
// Shared types and constants of the interval scheduling counter.
package isc_pkg;

    localparam int MAX_INTERVALS = 256;
    localparam int TIME_SCALE    = 100;
    localparam int COUNT_MAX     = 511;
    localparam int KEY_W         = 12;
    localparam int FILL_W        = $clog2(MAX_INTERVALS + 1);
    localparam int QDEPTH        = 4;
    localparam int QPTR_W        = $clog2(QDEPTH);
    localparam int QCNT_W        = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [4:0] start_hour;
        logic [5:0] start_minute;
        logic [4:0] end_hour;
        logic [5:0] end_minute;
        logic       last_interval;
    } isc_in_t;

    typedef struct packed {
        logic [8:0] selected_count;
        logic       overflow;
    } isc_out_t;

    // Sort key: end time first, start time breaks ties.
    typedef struct packed {
        logic [KEY_W-1:0] end_key;
        logic [KEY_W-1:0] start_key;
    } isc_key_t;

    typedef struct packed {
        isc_key_t key;
        logic     store;
        logic     last;
        logic     overflow;
    } isc_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } isc_qstat_t;

endpackage

// ===== sv/isc_queue.sv =====
// Short FIFO that decouples the intake front end from the sorting back end.
`include "interval_scheduling_count_macros.svh"

module isc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  isc_pkg::isc_entry_t wr_entry,
    input  logic                pop,
    output isc_pkg::isc_entry_t rd_entry,
    output isc_pkg::isc_qstat_t qstat
);
    import isc_pkg::*;

    isc_entry_t        mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    assign rd_entry    = mem_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign qstat.empty = (count_reg == '0);

    `ISC_ASSERT_IMPL(a_no_push_when_full, push, !qstat.full, "queue written while full")
    `ISC_ASSERT_IMPL(a_no_pop_when_empty, pop, !qstat.empty, "queue read while empty")

endmodule

// ===== sv/isc_front.sv =====
// Intake front end: converts times to keys, tracks fill and overflow per set.
module isc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  isc_pkg::isc_in_t    item,
    input  isc_pkg::isc_qstat_t qstat,
    output logic                push,
    output isc_pkg::isc_entry_t entry
);
    import isc_pkg::*;

    logic [FILL_W-1:0] stored_reg, stored_next;
    logic              ovf_reg, ovf_next;
    logic              room;

    function automatic logic [KEY_W-1:0] time_key(input logic [4:0] hour,
                                                  input logic [5:0] minute);
        return KEY_W'(hour) * KEY_W'(TIME_SCALE) + KEY_W'(minute);
    endfunction

    assign item_stall = qstat.full;
    assign push       = item_valid && !qstat.full;
    assign room       = (stored_reg != FILL_W'(MAX_INTERVALS));

    always_comb
    begin
        entry.key.start_key = time_key(item.start_hour, item.start_minute);
        entry.key.end_key   = time_key(item.end_hour, item.end_minute);
        entry.store         = room;
        entry.last          = item.last_interval;
        entry.overflow      = ovf_reg || !room;

        stored_next = stored_reg;
        ovf_next    = ovf_reg;
        if (push)
        begin
            if (item.last_interval)
            begin
                stored_next = '0;
                ovf_next    = 1'b0;
            end
            else if (room)
            begin
                stored_next = stored_reg + 1'b1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_reg <= '0;
            ovf_reg    <= 1'b0;
        end
        else
        begin
            stored_reg <= stored_next;
            ovf_reg    <= ovf_next;
        end
    end

endmodule

// ===== sv/isc_back.sv =====
// Back end: sorted insertion chain, greedy scan and the result register.
`include "interval_scheduling_count_macros.svh"

module isc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  isc_pkg::isc_entry_t entry,
    input  isc_pkg::isc_qstat_t qstat,
    output logic                pop,
    output logic                result_valid,
    input  logic                result_stall,
    output isc_pkg::isc_out_t   result
);
    import isc_pkg::*;

    typedef enum logic {ST_LOAD, ST_SCAN} state_t;

    localparam int SECOND = (MAX_INTERVALS > 1) ? 1 : 0;

    state_t             state_reg, state_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [FILL_W-1:0]  taken_reg, taken_next;
    logic [KEY_W-1:0]   last_end_reg, last_end_next;
    logic               ovf_reg, ovf_next;
    logic               result_valid_reg, result_valid_next;
    isc_out_t           result_reg, result_next;
    isc_key_t           key_reg [MAX_INTERVALS];
    isc_key_t           key_next [MAX_INTERVALS];
    logic [MAX_INTERVALS-1:0] after;
    logic               insert, scan_last, out_free, advance, take;
    logic [FILL_W-1:0]  taken_inc;
    logic               head_check, head_ordered;

    assign pop       = (state_reg == ST_LOAD) && !qstat.empty;
    assign insert    = pop && entry.store;
    assign scan_last = (fill_reg == FILL_W'(1));
    assign out_free  = !result_valid_reg || !result_stall;
    assign advance   = (state_reg == ST_SCAN) && (!scan_last || out_free);
    assign take      = (taken_reg == '0) || (key_reg[0].start_key >= last_end_reg);
    assign taken_inc = take ? taken_reg + 1'b1 : taken_reg;

    // A cell lies after the new key when it is empty or holds a larger key;
    // equal keys keep their place ahead of the newcomer.
    always_comb
    begin
        for (int i = 0; i < MAX_INTERVALS; i++)
        begin
            after[i] = (FILL_W'(i) >= fill_reg) || (entry.key < key_reg[i]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_INTERVALS; i++)
        begin
            key_next[i] = key_reg[i];
        end
        if (advance)
        begin
            for (int i = 0; i < MAX_INTERVALS - 1; i++)
            begin
                key_next[i] = key_reg[i + 1];
            end
        end
        else if (insert)
        begin
            if (after[0])
            begin
                key_next[0] = entry.key;
            end
            for (int i = 1; i < MAX_INTERVALS; i++)
            begin
                if (after[i])
                begin
                    key_next[i] = after[i - 1] ? key_reg[i - 1] : entry.key;
                end
            end
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        fill_next         = fill_reg;
        taken_next        = taken_reg;
        last_end_next     = last_end_reg;
        ovf_next          = ovf_reg;
        result_valid_next = result_valid_reg && result_stall;
        result_next       = result_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (insert)
                begin
                    fill_next = fill_reg + 1'b1;
                end
                if (pop && entry.last)
                begin
                    state_next = ST_SCAN;
                    taken_next = '0;
                    ovf_next   = entry.overflow;
                end
            end
            ST_SCAN:
            begin
                if (advance)
                begin
                    fill_next  = fill_reg - 1'b1;
                    taken_next = taken_inc;
                    if (take)
                    begin
                        last_end_next = key_reg[0].end_key;
                    end
                    if (scan_last)
                    begin
                        state_next                 = ST_LOAD;
                        result_valid_next          = 1'b1;
                        result_next.selected_count =
                            (32'(taken_inc) > COUNT_MAX) ? 9'(COUNT_MAX) : 9'(taken_inc);
                        result_next.overflow       = ovf_reg;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_LOAD;
            fill_reg         <= '0;
            taken_reg        <= '0;
            last_end_reg     <= '0;
            ovf_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            fill_reg         <= fill_next;
            taken_reg        <= taken_next;
            last_end_reg     <= last_end_next;
            ovf_reg          <= ovf_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_INTERVALS; i++)
        begin
            key_reg[i] <= key_next[i];
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // The two leading cells of a loaded chain must be in order.
    assign head_check   = (state_reg == ST_LOAD) && (fill_reg >= FILL_W'(2));
    assign head_ordered = !(key_reg[0] > key_reg[SECOND]);

    `ISC_ASSERT_IMPL(a_scan_not_empty, state_reg == ST_SCAN, fill_reg != '0, "scan with empty chain")
    `ISC_ASSERT_IMPL(a_head_sorted, head_check, head_ordered, "chain head out of order")

endmodule

// ===== sv/interval_scheduling_count.sv =====
// Interval scheduling counter: greedy earliest-finish selection over a set of intervals.
//
// Input channel (item_valid / item_stall / item): one interval per item, with start and
// end given as hour and minute; last_interval marks the final interval of a set. An item
// is taken at a rising edge with item_valid high and item_stall low. Up to 256 intervals
// are kept per set; further ones are dropped and reported through the overflow flag.
// Output channel (result_valid / result_stall / result): one item per set, carrying the
// number of intervals chosen without overlap and the overflow flag.
// Throughput: one interval per cycle while a set is loading and item_stall is low. Each
// interval is inserted into a sorted chain of cells. After the last interval, the chain
// is shifted out through the greedy counter at one entry per cycle, waiting at the final
// entry while a stalled result still holds the result register.
// With an empty queue, the last interval is moved from the queue into the chain once
// accepted, then the chain is scanned and the result registered at its final step.
// A four-entry queue between intake and sorting lets new intervals be taken while the
// previous set is still being scanned.
// Reset clears the fill counts, queue pointers and result register; the cells themselves
// need no clearing. A stalled result is held in its register; the scan of the next set
// waits at its final step until the register is free, and the queue then fills and
// raises item_stall.
module interval_scheduling_count (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  isc_pkg::isc_in_t  item,
    output logic              result_valid,
    input  logic              result_stall,
    output isc_pkg::isc_out_t result
);
    import isc_pkg::*;

    isc_qstat_t qstat;
    isc_entry_t wr_entry;
    isc_entry_t rd_entry;
    logic       push;
    logic       pop;

    // Intake: time keys, per-set fill count and overflow tracking.
    isc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .qstat      (qstat),
        .push       (push),
        .entry      (wr_entry)
    );

    // Decoupling queue between intake and the sorting engine.
    isc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (pop),
        .rd_entry (rd_entry),
        .qstat    (qstat)
    );

    // Sorting chain, greedy scan and output register.
    isc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .entry        (rd_entry),
        .qstat        (qstat),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== bench/tb_interval_scheduling_count.sv =====
// Self-checking testbench for the interval scheduling counter: directed sets, then random sets.
module tb_interval_scheduling_count;
    timeunit 1ns;
    timeprecision 1ps;

    import isc_pkg::*;

    // The random part stops after about this many intervals.
    localparam int RANDOM_INTERVALS = 1400;
    // Hard stop. A correct run needs well under a tenth of this, even with every
    // interval waiting out the longest gap, every count waiting out the longest
    // stall, and the scan of each set stepping through every held interval.
    localparam int CYCLE_LIMIT = 400000;
    // Quiet time after the last count: one full scan of the store and then some.
    localparam int TAIL_CYCLES = MAX_INTERVALS + 16;
    localparam int DIRECTED_ROWS = 19;
    localparam int KEY_PAIR_W = 2 * KEY_W;

    // One row of the directed table. Where has_count is set, the count is typed
    // in by hand; all other rows are checked against the predictor.
    typedef struct packed {
        isc_in_t  interval;
        logic     has_count;
        isc_out_t hand_count;
    } directed_row_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     item_valid = 1'b0;
    logic     item_stall;
    isc_in_t  item = '0;
    logic     result_valid;
    logic     result_stall = 1'b1;
    isc_out_t result;

    // Predictor state: the sort keys of the intervals held for the current set,
    // and whether an interval of the set was dropped because the store was full.
    logic [KEY_PAIR_W-1:0] held_keys[$];
    bit                    held_dropped = 1'b0;

    // Counts still owed by the block, oldest first.
    isc_out_t pending_counts[$];

    int unsigned   mismatch_count = 0;
    int unsigned   cycle_count = 0;
    int unsigned   stall_left = 0;
    bit            tx_calm = 1'b0;
    bit            rx_calm = 1'b0;
    isc_in_t       last_made = '0;
    directed_row_t directed_rows[DIRECTED_ROWS];

    interval_scheduling_count dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #1 clk = ~clk;

    // The run is bounded no matter what the block does.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic report_mismatch(string what);
        mismatch_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // Predictor. Each interval is turned into a key with the end time in the
    // upper half and the start time in the lower half, so that a plain numeric
    // sort orders by end time and breaks ties by start time. Times are
    // hour*100+minute as given, with no range check, so hours up to 31 and
    // minutes up to 63 are keyed just like legal ones. Returns 1 when the
    // interval closes a set, with the count the block must produce.
    function automatic bit absorb_interval(isc_in_t iv, output isc_out_t count_out);
        isc_key_t              key;
        logic [KEY_PAIR_W-1:0] ordered[$];
        isc_key_t              probe;
        logic [KEY_W-1:0]      last_end;
        int unsigned           taken;
        count_out = '0;
        key.start_key = KEY_W'(iv.start_hour * TIME_SCALE + iv.start_minute);
        key.end_key   = KEY_W'(iv.end_hour * TIME_SCALE + iv.end_minute);
        if (held_keys.size() < MAX_INTERVALS)
            held_keys.push_back(key);
        else
            held_dropped = 1'b1;
        if (!iv.last_interval)
            return 1'b0;

        // Greedy earliest finish: the first interval is always taken, and a
        // later one only when it starts no earlier than the last taken end.
        ordered = held_keys;
        ordered.sort();
        probe = ordered[0];
        last_end = probe.end_key;
        taken = 1;
        for (int i = 1; i < ordered.size(); i++)
        begin
            probe = ordered[i];
            if (probe.start_key >= last_end)
            begin
                last_end = probe.end_key;
                taken++;
            end
        end
        // The count never exceeds the store depth, so it always fits the field.
        count_out.selected_count = 9'(taken);
        count_out.overflow = held_dropped;
        held_keys.delete();
        held_dropped = 1'b0;
        return 1'b1;
    endfunction

    // Sender. The interval goes out after a random gap, unless the current
    // stretch is calm. Valid stays high from one item to the next when there
    // is no gap, so it is never lowered and raised in the same step. Once the
    // item is taken, the predictor sees it; a hand-typed count replaces the
    // predicted one in the queue of owed counts.
    task automatic send_interval(isc_in_t iv, bit has_count, isc_out_t hand_count);
        int unsigned gap;
        isc_out_t    predicted;
        gap = tx_calm ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= iv;
        do
            @(posedge clk);
        while (item_stall);
        if (absorb_interval(iv, predicted))
            pending_counts.push_back(has_count ? hand_count : predicted);
    endtask

    // Stops sending until every owed count has come back. At least one edge
    // passes, so a following send never drives valid twice in one step.
    task automatic drain_counts();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_counts.size() != 0);
    endtask

    // Minute of day to hour and minute fields, clipped to the last minute.
    function automatic void set_end(inout isc_in_t iv, input int unsigned minute_of_day);
        if (minute_of_day > 1439)
            minute_of_day = 1439;
        iv.end_hour = 5'(minute_of_day / 60);
        iv.end_minute = 6'(minute_of_day % 60);
    endfunction

    // Random interval near a base hour, so that the intervals of a set overlap
    // often and the greedy choice matters. A few are raw bit patterns (times
    // out of range, reversed order), some repeat the previous interval, some
    // start exactly where the previous one ended, and some are reversed.
    function automatic isc_in_t make_interval(int unsigned base_hour);
        isc_in_t     iv;
        int unsigned pick;
        int unsigned start_min;
        pick = $urandom_range(0, 19);
        iv = last_made;
        if (pick < 2)
        begin
            iv.start_hour = 5'($urandom);
            iv.start_minute = 6'($urandom);
            iv.end_hour = 5'($urandom);
            iv.end_minute = 6'($urandom);
        end
        else if (pick < 4)
        begin
            // Exact copy of the previous interval.
        end
        else if (pick < 7)
        begin
            iv.start_hour = last_made.end_hour;
            iv.start_minute = last_made.end_minute;
            start_min = last_made.end_hour * 60 + last_made.end_minute;
            set_end(iv, start_min + $urandom_range(0, 120));
        end
        else
        begin
            start_min = base_hour * 60 + $urandom_range(0, 239);
            if (start_min > 1439)
                start_min = 1439;
            iv.start_hour = 5'(start_min / 60);
            iv.start_minute = 6'(start_min % 60);
            set_end(iv, start_min + $urandom_range(0, 150));
            if (pick == 7)
            begin
                // Reversed: the end lies at or before the start.
                {iv.start_hour, iv.start_minute, iv.end_hour, iv.end_minute} =
                    {iv.end_hour, iv.end_minute, iv.start_hour, iv.start_minute};
            end
        end
        iv.last_interval = 1'b0;
        last_made = iv;
        return iv;
    endfunction

    // Receiver. A count is taken at an edge where valid is high and stall is
    // low; it is compared field by field with the oldest owed count. After
    // each taken count a new stall length is drawn; it counts down only while
    // a count is offered, so the stall lands on the output rather than on
    // idle time. In a calm stretch the receiver never stalls.
    always @(posedge clk)
    begin
        isc_out_t owed;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_counts.size() == 0)
                report_mismatch($sformatf("count %0d overflow %0b with nothing owed",
                                          result.selected_count, result.overflow));
            else
            begin
                owed = pending_counts.pop_front();
                if (result.selected_count !== owed.selected_count)
                    report_mismatch($sformatf("selected_count %0d, expected %0d",
                                              result.selected_count, owed.selected_count));
                if (result.overflow !== owed.overflow)
                    report_mismatch($sformatf("overflow %0b, expected %0b",
                                              result.overflow, owed.overflow));
            end
            stall_left = rx_calm ? 0 : $urandom_range(0, 9);
        end
        else if (result_valid && stall_left != 0)
            stall_left = stall_left - 1;
        result_stall <= (stall_left != 0);
    end

    initial
    begin
        int unsigned sent;
        int unsigned set_size;
        int unsigned base_hour;
        bit          full_done;
        bit          over_done;
        isc_in_t     iv;

        // Fields are hour, minute of start, hour, minute of end, last flag.
        directed_rows = '{
            // A single empty interval at midnight.
            '{'{5'd0, 6'd0, 5'd0, 6'd0, 1'b1}, 1'b1, '{9'd1, 1'b0}},
            // All field bits set: out-of-range time, one interval.
            '{'{5'd31, 6'd63, 5'd31, 6'd63, 1'b1}, 1'b1, '{9'd1, 1'b0}},
            // Abutting chain: a start equal to the last end is taken.
            '{'{5'd9, 6'd0, 5'd10, 6'd0, 1'b0}, 1'b0, '0},
            '{'{5'd10, 6'd0, 5'd11, 6'd0, 1'b0}, 1'b0, '0},
            '{'{5'd11, 6'd0, 5'd12, 6'd0, 1'b1}, 1'b1, '{9'd3, 1'b0}},
            // Everything overlaps the earliest finisher.
            '{'{5'd9, 6'd0, 5'd12, 6'd0, 1'b0}, 1'b0, '0},
            '{'{5'd10, 6'd0, 5'd11, 6'd0, 1'b0}, 1'b0, '0},
            '{'{5'd10, 6'd30, 5'd11, 6'd30, 1'b1}, 1'b1, '{9'd1, 1'b0}},
            // Reversed interval next to an empty one.
            '{'{5'd23, 6'd59, 5'd0, 6'd0, 1'b0}, 1'b0, '0},
            '{'{5'd0, 6'd0, 5'd0, 6'd0, 1'b1}, 1'b0, '0},
            // Minutes and hours out of range, used as given.
            '{'{5'd1, 6'd63, 5'd2, 6'd0, 1'b0}, 1'b0, '0},
            '{'{5'd2, 6'd0, 5'd24, 6'd0, 1'b0}, 1'b0, '0},
            '{'{5'd0, 6'd62, 5'd1, 6'd61, 1'b1}, 1'b0, '0},
            // Equal end times: the start breaks the tie.
            '{'{5'd5, 6'd0, 5'd6, 6'd0, 1'b0}, 1'b0, '0},
            '{'{5'd5, 6'd30, 5'd6, 6'd0, 1'b0}, 1'b0, '0},
            '{'{5'd6, 6'd0, 5'd6, 6'd0, 1'b1}, 1'b0, '0},
            // Identical intervals.
            '{'{5'd12, 6'd0, 5'd13, 6'd0, 1'b0}, 1'b0, '0},
            '{'{5'd12, 6'd0, 5'd13, 6'd0, 1'b0}, 1'b0, '0},
            '{'{5'd12, 6'd0, 5'd13, 6'd0, 1'b1}, 1'b0, '0}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with both sides idling at random.
        foreach (directed_rows[r])
            send_interval(directed_rows[r].interval, directed_rows[r].has_count,
                          directed_rows[r].hand_count);
        // Hold off until the block has answered every directed set.
        drain_counts();

        // Random part. Most sets are small; one fills the store exactly and
        // one runs past it, so that intervals are dropped and the flag is set,
        // and the set after it shows the flag cleared again.
        sent = 0;
        full_done = 1'b0;
        over_done = 1'b0;
        while (sent < RANDOM_INTERVALS)
        begin
            if (!full_done && sent >= 300)
            begin
                set_size = MAX_INTERVALS;
                full_done = 1'b1;
            end
            else if (!over_done && sent >= 800)
            begin
                set_size = MAX_INTERVALS + $urandom_range(1, 4);
                over_done = 1'b1;
            end
            else if ($urandom_range(0, 7) == 0)
                set_size = $urandom_range(9, 40);
            else
                set_size = $urandom_range(1, 8);

            // Some sets run with no idling on one side or the other.
            tx_calm = ($urandom_range(0, 4) == 0);
            rx_calm = ($urandom_range(0, 4) == 0);
            base_hour = $urandom_range(0, 20);
            for (int k = 0; k < set_size; k++)
            begin
                iv = make_interval(base_hour);
                iv.last_interval = (k == set_size - 1);
                send_interval(iv, 1'b0, '0);
            end
            sent += set_size;

            // Now and then the sender waits for the block to empty.
            if ($urandom_range(0, 9) == 0)
                drain_counts();
        end

        drain_counts();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
